// ----- sv/ahfc_pkg.sv -----
// Shared types, constants and a helper function for the ASCII hex frame checker.
package ahfc_pkg;

   localparam int HEADER_BYTES = 15;
   localparam int POS_W        = 9;
   localparam int SUM_W        = POS_W + 1;
   localparam int LINK_SLOTS   = 4;
   localparam int SERVER_SLOTS = 8;

   typedef logic [POS_W-1:0] pos_type;
   typedef logic [SUM_W-1:0] sum_type;

   localparam pos_type POS_KIND_HI = pos_type'(11);
   localparam pos_type POS_KIND_LO = pos_type'(12);
   localparam pos_type POS_LEN_HI  = pos_type'(13);
   localparam pos_type POS_LEN_LO  = pos_type'(14);
   localparam pos_type POS_MAX     = '1;

   typedef enum logic {
      MODE_LINK   = 1'b0,
      MODE_SERVER = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_CHECKSUM = 2'd1,
      STATUS_LENGTH   = 2'd2,
      STATUS_DIGIT    = 2'd3
   } status_type;

   localparam logic [7:0] LINK_TABLE [LINK_SLOTS] = '{8'h40, 8'h41, 8'h42, 8'h43};
   localparam logic [7:0] SERVER_TABLE [SERVER_SLOTS] =
      '{8'h0B, 8'h14, 8'h16, 8'h17, 8'h20, 8'h21, 8'h22, 8'h23};

   typedef struct packed {
      logic       known;
      logic [2:0] slot;
   } lookup_type;

   typedef struct packed {
      logic       bad;
      logic [3:0] nib;
   } nibble_type;

   // Decodes one ASCII hex character; anything else is flagged and reads as zero.
   function automatic nibble_type hex_nibble(input logic [7:0] c);
      nibble_type r;
      r.bad = 1'b0;
      r.nib = 4'h0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.nib = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r.nib = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r.nib = 4'(c - 8'h57);
      end else begin
         r.bad = 1'b1;
      end
      return r;
   endfunction

endpackage

// ----- sv/ahfc_kind_lookup.sv -----
// Handler table lookup of a frame type in the table of the selected mode.
module ahfc_kind_lookup (
   input  ahfc_pkg::mode_type   mode,
   input  logic [7:0]           kind,
   output ahfc_pkg::lookup_type result
);
   import ahfc_pkg::*;

   lookup_type link_hit;
   lookup_type server_hit;

   // Scanning from the top down leaves the lowest matching slot.
   always_comb begin
      link_hit = '0;
      for (int i = LINK_SLOTS - 1; i >= 0; i--) begin
         if (LINK_TABLE[i] == kind) begin
            link_hit.known = 1'b1;
            link_hit.slot  = 3'(i);
         end
      end
   end

   always_comb begin
      server_hit = '0;
      for (int i = SERVER_SLOTS - 1; i >= 0; i--) begin
         if (SERVER_TABLE[i] == kind) begin
            server_hit.known = 1'b1;
            server_hit.slot  = 3'(i);
         end
      end
   end

   assign result = (mode == MODE_SERVER) ? server_hit : link_hit;

endmodule

// ----- sv/ascii_hex_frame_checker.sv -----
// Top level of the ASCII hex frame checker with XOR block check.
// Frames enter one byte per transfer, header first, with req_frame_end set on the final
// byte. Payload bytes come out as they arrive; the final byte yields one report with the
// decoded type, its handler table lookup and a status (checksum, length, bad hex digit).
// The block takes one byte per cycle: each byte passes an input register and one step of
// decode, XOR and position logic into the result register, and a stalled result holds
// back the input only once the input register is full as well.
// csr_wr_data selects the table: 0 link table with checksum check, 1 server table without.
module ascii_hex_frame_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       req_frame_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_report,
   output logic [7:0] rsp_payload_byte,
   output logic [7:0] rsp_frame_kind,
   output logic       rsp_kind_known,
   output logic [2:0] rsp_handler_slot,
   output logic [1:0] rsp_frame_status
);
   import ahfc_pkg::*;

   mode_type    mode_ff;
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_end_ff;

   pos_type     pos_ff, pos_in;
   logic [7:0]  xor_ff, xor_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  kind_ff, kind_in;
   logic [7:0]  sent_ff, sent_in;
   logic        dig_err_ff, dig_err_in;
   logic        len_err_ff, len_err_in;

   logic        rsp_valid_ff;
   logic        rsp_is_report_ff, rsp_is_report_in;
   logic [7:0]  rsp_payload_ff, rsp_payload_in;
   logic [7:0]  rsp_kind_ff, rsp_kind_in;
   logic        rsp_known_ff, rsp_known_in;
   logic [2:0]  rsp_slot_ff, rsp_slot_in;
   status_type  rsp_status_ff, rsp_status_in;

   logic        out_free;
   logic        fire;
   logic        produce;
   logic        is_payload;
   sum_type     pos_ext;
   sum_type     cks_pos;
   nibble_type  dec;
   lookup_type  lookup;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign produce   = in_end_ff || is_payload;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   assign pos_ext = {1'b0, pos_ff};
   assign cks_pos = sum_type'(HEADER_BYTES) + {{(SUM_W-8){1'b0}}, len_ff};
   assign dec     = hex_nibble(in_byte_ff);

   ahfc_kind_lookup u_lookup (
      .mode   (mode_ff),
      .kind   (kind_in),
      .result (lookup)
   );

   always_comb begin
      xor_in     = xor_ff;
      len_in     = len_ff;
      kind_in    = kind_ff;
      sent_in    = sent_ff;
      dig_err_in = dig_err_ff;
      len_err_in = len_err_ff;
      is_payload = 1'b0;

      if (pos_ext < cks_pos) begin
         xor_in = xor_ff ^ in_byte_ff;
      end

      if (pos_ff == POS_KIND_HI) begin
         kind_in = {dec.nib, 4'h0};
         dig_err_in = dig_err_ff | dec.bad;
      end else if (pos_ff == POS_KIND_LO) begin
         kind_in = kind_ff | {4'h0, dec.nib};
         dig_err_in = dig_err_ff | dec.bad;
      end else if (pos_ff == POS_LEN_HI) begin
         len_in = {dec.nib, 4'h0};
         dig_err_in = dig_err_ff | dec.bad;
      end else if (pos_ff == POS_LEN_LO) begin
         len_in = len_ff | {4'h0, dec.nib};
         dig_err_in = dig_err_ff | dec.bad;
      end else if (pos_ext >= sum_type'(HEADER_BYTES)) begin
         if (pos_ext < cks_pos) begin
            is_payload = 1'b1;
         end else if (pos_ext == cks_pos) begin
            sent_in = {dec.nib, 4'h0};
            dig_err_in = dig_err_ff | (dec.bad && mode_ff == MODE_LINK);
         end else if (pos_ext == cks_pos + sum_type'(1)) begin
            sent_in = sent_ff | {4'h0, dec.nib};
            dig_err_in = dig_err_ff | (dec.bad && mode_ff == MODE_LINK);
         end else if (pos_ext > cks_pos + sum_type'(2) && !in_end_ff) begin
            len_err_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_is_report_in = in_end_ff;
      rsp_payload_in   = in_end_ff ? 8'h00 : in_byte_ff;
      rsp_kind_in      = in_end_ff ? kind_in : 8'h00;
      rsp_known_in     = in_end_ff && lookup.known;
      rsp_slot_in      = in_end_ff ? lookup.slot : 3'd0;
      rsp_status_in    = STATUS_OK;
      if (in_end_ff) begin
         if (dig_err_in) begin
            rsp_status_in = STATUS_DIGIT;
         end else if (len_err_in || pos_ext != cks_pos + sum_type'(2)) begin
            rsp_status_in = STATUS_LENGTH;
         end else if (mode_ff == MODE_LINK && xor_in != sent_in) begin
            rsp_status_in = STATUS_CHECKSUM;
         end
      end
   end

   always_comb begin
      pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + pos_type'(1);
      if (in_end_ff) begin
         pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_LINK;
         in_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= mode_type'(csr_wr_data);
         end
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
         in_end_ff  <= req_frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         xor_ff     <= 8'h00;
         len_ff     <= 8'h00;
         kind_ff    <= 8'h00;
         sent_ff    <= 8'h00;
         dig_err_ff <= 1'b0;
         len_err_ff <= 1'b0;
      end else if (fire) begin
         pos_ff <= pos_in;
         if (in_end_ff) begin
            xor_ff     <= 8'h00;
            len_ff     <= 8'h00;
            kind_ff    <= 8'h00;
            sent_ff    <= 8'h00;
            dig_err_ff <= 1'b0;
            len_err_ff <= 1'b0;
         end else begin
            xor_ff     <= xor_in;
            len_ff     <= len_in;
            kind_ff    <= kind_in;
            sent_ff    <= sent_in;
            dig_err_ff <= dig_err_in;
            len_err_ff <= len_err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= fire && produce;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && produce) begin
         rsp_is_report_ff <= rsp_is_report_in;
         rsp_payload_ff   <= rsp_payload_in;
         rsp_kind_ff      <= rsp_kind_in;
         rsp_known_ff     <= rsp_known_in;
         rsp_slot_ff      <= rsp_slot_in;
         rsp_status_ff    <= rsp_status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_report    = rsp_is_report_ff;
   assign rsp_payload_byte = rsp_payload_ff;
   assign rsp_frame_kind   = rsp_kind_ff;
   assign rsp_kind_known   = rsp_known_ff;
   assign rsp_handler_slot = rsp_slot_ff;
   assign rsp_frame_status = rsp_status_ff;

   a_end_clears_position : assert property (@(posedge clock) disable iff (reset)
      fire && in_end_ff |=> pos_ff == '0)
      else $error("Frame position not cleared after the final byte.");

   a_unknown_slot_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_known_ff |-> rsp_slot_ff == 3'd0)
      else $error("Unknown frame type reported with a nonzero handler slot.");

   a_payload_fields_clear : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_is_report_ff |-> rsp_kind_ff == 8'h00 && !rsp_known_ff
         && rsp_status_ff == STATUS_OK)
      else $error("Payload transfer carries report fields.");

   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && in_valid_ff)
      else $error("Input stalled while a register stage was free.");

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the ASCII hex frame checker with a frame tracker and random frames.
`timescale 1ns / 100ps

module tb_top;
   import ahfc_pkg::*;

   typedef struct packed {
      logic       is_report;
      logic [7:0] payload_byte;
      logic [7:0] frame_kind;
      logic       kind_known;
      logic [2:0] handler_slot;
      status_type frame_status;
   } result_type;

   class frame_tracker;
      mode_type    mode;
      pos_type     next_pos;
      logic [7:0]  check_xor;
      logic [7:0]  payload_len;
      logic [7:0]  kind;
      logic [7:0]  sent_sum;
      logic        digit_bad;
      logic        length_bad;
      result_type  pending_results[$];
      int          mismatches;

      function new();
         mode = MODE_LINK;
         mismatches = 0;
         clear_frame();
      endfunction

      static function logic [3:0] hex_digit(input logic [7:0] c, output logic bad);
         bad = 1'b0;
         if (c >= "0" && c <= "9") begin
            return c[3:0];
         end
         if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
            return c[3:0] + 4'd9;
         end
         bad = 1'b1;
         return 4'h0;
      endfunction

      function void clear_frame();
         next_pos = '0;
         check_xor = 8'h00;
         payload_len = 8'h00;
         kind = 8'h00;
         sent_sum = 8'h00;
         digit_bad = 1'b0;
         length_bad = 1'b0;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function void take_byte(input logic [7:0] b, input logic last);
         int          p;
         int          sum_at;
         logic        bad;
         logic [3:0]  nib;
         logic        payload;
         result_type  r;
         p = int'(next_pos);
         sum_at = HEADER_BYTES + int'(payload_len);
         nib = hex_digit(b, bad);
         payload = 1'b0;
         if (p < HEADER_BYTES || p < sum_at) begin
            check_xor ^= b;
         end
         case (next_pos)
            POS_KIND_HI: begin
               kind = {nib, 4'h0};
               digit_bad |= bad;
            end
            POS_KIND_LO: begin
               kind = kind | {4'h0, nib};
               digit_bad |= bad;
            end
            POS_LEN_HI: begin
               payload_len = {nib, 4'h0};
               digit_bad |= bad;
            end
            POS_LEN_LO: begin
               payload_len = payload_len | {4'h0, nib};
               digit_bad |= bad;
            end
            default: begin
               if (p >= HEADER_BYTES) begin
                  if (p < sum_at) begin
                     payload = 1'b1;
                  end else if (p == sum_at) begin
                     sent_sum = {nib, 4'h0};
                     if (bad && mode == MODE_LINK) digit_bad = 1'b1;
                  end else if (p == sum_at + 1) begin
                     sent_sum = sent_sum | {4'h0, nib};
                     if (bad && mode == MODE_LINK) digit_bad = 1'b1;
                  end else if (p > sum_at + 2 && !last) begin
                     length_bad = 1'b1;
                  end
               end
            end
         endcase
         if (last) begin
            r = '0;
            r.is_report = 1'b1;
            r.frame_kind = kind;
            if (mode == MODE_LINK) begin
               for (int i = 0; i < LINK_SLOTS; i++) begin
                  if (!r.kind_known && LINK_TABLE[i] == kind) begin
                     r.kind_known = 1'b1;
                     r.handler_slot = 3'(i);
                  end
               end
            end else begin
               for (int i = 0; i < SERVER_SLOTS; i++) begin
                  if (!r.kind_known && SERVER_TABLE[i] == kind) begin
                     r.kind_known = 1'b1;
                     r.handler_slot = 3'(i);
                  end
               end
            end
            if (digit_bad) begin
               r.frame_status = STATUS_DIGIT;
            end else if (length_bad || p != sum_at + 2) begin
               r.frame_status = STATUS_LENGTH;
            end else if (mode == MODE_LINK && check_xor != sent_sum) begin
               r.frame_status = STATUS_CHECKSUM;
            end else begin
               r.frame_status = STATUS_OK;
            end
            pending_results.push_back(r);
            clear_frame();
            return;
         end
         if (next_pos != POS_MAX) next_pos = next_pos + pos_type'(1);
         if (payload) begin
            r = '0;
            r.payload_byte = b;
            pending_results.push_back(r);
         end
      endfunction

      function void match_result(input result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected transfer: report=%0b byte=%02h kind=%02h ",
                        got.is_report, got.payload_byte, got.frame_kind,
                        "known=%0b slot=%0d status=%0d",
                        got.kind_known, got.handler_slot, got.frame_status);
            end
            return;
         end
         want = pending_results.pop_front();
         if (got.is_report !== want.is_report || got.payload_byte !== want.payload_byte ||
             got.frame_kind !== want.frame_kind || got.kind_known !== want.kind_known ||
             got.handler_slot !== want.handler_slot ||
             got.frame_status !== want.frame_status) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: expected report=%0b byte=%02h kind=%02h ",
                        want.is_report, want.payload_byte, want.frame_kind,
                        "known=%0b slot=%0d status=%0d",
                        want.kind_known, want.handler_slot, want.frame_status);
               $display("          actual   report=%0b byte=%02h kind=%02h ",
                        got.is_report, got.payload_byte, got.frame_kind,
                        "known=%0b slot=%0d status=%0d",
                        got.kind_known, got.handler_slot, got.frame_status);
            end
         end
      endfunction

      function void close();
         if (pending_results.size() != 0) begin
            $display("%0d expected transfers never arrived", pending_results.size());
            mismatches += pending_results.size();
         end
      endfunction
   endclass

   typedef enum int {
      FLAW_NONE,
      FLAW_CHECKSUM,
      FLAW_DIGIT,
      FLAW_SHORT,
      FLAW_LONG,
      FLAW_NOISE
   } flaw_type;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int IDLE_CYCLES  = 6;
   localparam int PHASE_ITEMS  = 230;
   localparam int PHASES       = 6;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       req_frame_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_is_report;
   logic [7:0] rsp_payload_byte;
   logic [7:0] rsp_frame_kind;
   logic       rsp_kind_known;
   logic [2:0] rsp_handler_slot;
   logic [1:0] rsp_frame_status;

   frame_tracker tracker = new();
   logic [7:0]   frame_q[$];
   int           burst_left = 0;
   int           hold_left = 0;
   int           phase_items = 0;
   int           frame_count = 0;
   int           cycle_count = 0;

   ascii_hex_frame_checker u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .req_frame_end    (req_frame_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_is_report    (rsp_is_report),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_kind   (rsp_frame_kind),
      .rsp_kind_known   (rsp_kind_known),
      .rsp_handler_slot (rsp_handler_slot),
      .rsp_frame_status (rsp_frame_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic lower);
      if (nib < 4'd10) return 8'h30 + {4'h0, nib};
      return (lower ? 8'h61 : 8'h41) + {4'h0, nib} - 8'd10;
   endfunction

   function automatic void add_hex(input logic [7:0] v);
      logic lower;
      lower = 1'($urandom_range(0, 1));
      frame_q.push_back(hex_char(v[7:4], lower));
      frame_q.push_back(hex_char(v[3:0], lower));
   endfunction

   function automatic logic [7:0] frame_xor();
      logic [7:0] sum;
      sum = 8'h00;
      foreach (frame_q[i]) sum ^= frame_q[i];
      return sum;
   endfunction

   function automatic logic [7:0] non_hex_char();
      logic [7:0] c;
      logic       bad;
      bad = 1'b0;
      while (!bad) begin
         c = 8'($urandom);
         void'(frame_tracker::hex_digit(c, bad));
      end
      return c;
   endfunction

   function automatic logic [7:0] pick_kind();
      mode_type other;
      other = (tracker.mode == MODE_LINK) ? MODE_SERVER : MODE_LINK;
      case ($urandom_range(0, 4))
         0, 1, 2: begin
            if (tracker.mode == MODE_LINK) return LINK_TABLE[$urandom_range(0, LINK_SLOTS - 1)];
            return SERVER_TABLE[$urandom_range(0, SERVER_SLOTS - 1)];
         end
         3: begin
            if (other == MODE_LINK) return LINK_TABLE[$urandom_range(0, LINK_SLOTS - 1)];
            return SERVER_TABLE[$urandom_range(0, SERVER_SLOTS - 1)];
         end
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void make_frame(input int plen, input logic [7:0] kind,
                                      input flaw_type flaw);
      logic [7:0] sum;
      int         n;
      int         spot;
      frame_q.delete();
      frame_q.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h02);
      repeat (10) frame_q.push_back(8'($urandom));
      add_hex(kind);
      add_hex(8'(plen));
      repeat (plen) frame_q.push_back(8'($urandom));
      sum = frame_xor();
      if (flaw == FLAW_CHECKSUM) sum ^= 8'($urandom_range(1, 255));
      add_hex(sum);
      frame_q.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h03);
      case (flaw)
         FLAW_DIGIT: begin
            spot = $urandom_range(0, 5);
            if (spot < 4) spot = spot + 11;
            else spot = frame_q.size() - 7 + spot;
            frame_q[spot] = non_hex_char();
         end
         FLAW_SHORT: begin
            n = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > n) void'(frame_q.pop_back());
         end
         FLAW_LONG: begin
            repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
         end
         FLAW_NOISE: begin
            frame_q.delete();
            repeat ($urandom_range(1, 30)) frame_q.push_back(8'($urandom));
         end
         default: begin
         end
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 60);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_frame_end <= last;
      do @(posedge clock); while (req_stall);
      tracker.take_byte(b, last);
      burst_left--;
   endtask

   task automatic send_frame();
      foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
      phase_items += frame_q.size();
      frame_count++;
   endtask

   task automatic send_random_frame();
      int       roll;
      int       plen;
      flaw_type flaw;
      roll = $urandom_range(0, 99);
      if (roll < 55) flaw = FLAW_NONE;
      else if (roll < 65) flaw = FLAW_CHECKSUM;
      else if (roll < 75) flaw = FLAW_DIGIT;
      else if (roll < 83) flaw = FLAW_SHORT;
      else if (roll < 90) flaw = FLAW_LONG;
      else flaw = FLAW_NOISE;
      plen = (frame_count % 45 == 20) ? 255 : $urandom_range(0, 12);
      make_frame(plen, pick_kind(), flaw);
      send_frame();
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input mode_type m);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.mode = m;
   endtask

   initial begin
      int          style;
      int          tick;
      result_type  got;
      style = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.is_report = rsp_is_report;
            got.payload_byte = rsp_payload_byte;
            got.frame_kind = rsp_frame_kind;
            got.kind_known = rsp_kind_known;
            got.handler_slot = rsp_handler_slot;
            got.frame_status = status_type'(rsp_frame_status);
            tracker.match_result(got);
         end
         tick++;
         if (tick % 200 == 0) style = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (style)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= (tick % 7 < 3);
               default: rsp_stall <= ($urandom_range(0, 9) < 7);
            endcase
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Short directed frames: a well-formed one at the field extremes, then two cut short.
      frame_q.delete();
      frame_q.push_back(8'h00);
      repeat (10) frame_q.push_back(8'hFF);
      frame_q.push_back("4");
      frame_q.push_back("3");
      frame_q.push_back("0");
      frame_q.push_back("1");
      frame_q.push_back(8'hFF);
      add_hex(frame_xor());
      frame_q.push_back(8'h03);
      send_frame();
      frame_q = '{8'h80, 8'h7F};
      send_frame();
      frame_q = '{8'h41};
      send_frame();
      wait_idle();

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph < 4) write_mode((ph % 2 == 0) ? MODE_SERVER : MODE_LINK);
         else write_mode(mode_type'($urandom_range(0, 1)));
         phase_items = 0;
         if (ph == 2) hold_left = 300;
         if (ph == 3) begin
            // Runs the byte position into saturation before the final byte.
            make_frame(0, pick_kind(), FLAW_NONE);
            repeat (500) frame_q.push_back(8'($urandom));
            send_frame();
         end
         while (phase_items < PHASE_ITEMS) send_random_frame();
         wait_idle();
      end

      tracker.close();
      if (tracker.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
